// ===== design/bsfb_pkg.sv =====
// ----------------------------------------------------------------------------
// Byte-stuffed frame builder package
// Shared word types, framing constants and the CRC-16 byte update.
// ----------------------------------------------------------------------------
package bsfb_pkg;

  localparam logic [7:0]  FLAG_BYTE = 8'h7E;
  localparam logic [7:0]  ESC_BYTE  = 8'h7D;
  localparam logic [7:0]  ESC_XOR   = 8'h20;
  localparam logic [15:0] CRC_INIT  = 16'hFFFF;
  localparam logic [15:0] CRC_POLY  = 16'h1021;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       payload_last;
  } bsfb_in_t;

  typedef struct packed {
    logic [7:0] line_byte;
    logic       run_last;
    logic       frame_done;
  } bsfb_out_t;

  // One classified input word as it travels from the front to the back.
  typedef struct packed {
    logic [7:0]  data_byte;
    logic        need_open;
    logic        last;
    logic [15:0] crc;
  } bsfb_cmd_t;

  // Queue status seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } bsfb_q_stat_t;

  // True for the two byte values that must be escaped on the line.
  function automatic logic is_special(input logic [7:0] b);
    return (b == FLAG_BYTE) || (b == ESC_BYTE);
  endfunction

  // CRC-16, polynomial 0x1021, MSB first, one byte.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== design/bsfb_front.sv =====
// ----------------------------------------------------------------------------
// Byte-stuffed frame builder: front end
// Accepts payload words, tracks the open frame and the running CRC, and
// turns each word into a command for the back end.
// ----------------------------------------------------------------------------
module bsfb_front
  import bsfb_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_push,
  input  bsfb_in_t     in_word,
  input  bsfb_q_stat_t q_stat,
  output logic         cmd_push,
  output bsfb_cmd_t    cmd
);

  logic        frame_open_r, frame_open_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [15:0] crc_upd;

  assign cmd_push = in_push && !q_stat.full;
  assign crc_upd  = crc_byte(crc_r, in_word.data_byte);

  always_comb begin
    cmd.data_byte  = in_word.data_byte;
    cmd.need_open  = !frame_open_r;
    cmd.last       = in_word.payload_last;
    cmd.crc        = crc_upd;
    frame_open_nxt = frame_open_r;
    crc_nxt        = crc_r;
    if (cmd_push) begin
      frame_open_nxt = !in_word.payload_last;
      crc_nxt        = in_word.payload_last ? CRC_INIT : crc_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_open_r <= 1'b0;
      crc_r        <= CRC_INIT;
    end else begin
      frame_open_r <= frame_open_nxt;
      crc_r        <= crc_nxt;
    end
  end

  // A closing word must leave the frame shut and the CRC restarted.
  a_close_restarts : assert property (@(posedge clk) disable iff (!rst_n)
    cmd_push && in_word.payload_last |=> !frame_open_r && (crc_r == CRC_INIT))
    else $error("frame state not restarted after last word");

endmodule

// ===== design/bsfb_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// Byte-stuffed frame builder: command queue
// Short first-in first-out queue that decouples the front end from the back.
// ----------------------------------------------------------------------------
module bsfb_cmd_fifo
  import bsfb_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  bsfb_cmd_t    push_cmd,
  input  logic         pop,
  output bsfb_cmd_t    head_cmd,
  output bsfb_q_stat_t stat
);

  bsfb_cmd_t          mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_AW:0]   count_r;

  assign stat.full  = (count_r == (FIFO_AW+1)'(FIFO_DEPTH));
  assign stat.empty = (count_r == '0);
  assign head_cmd   = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  a_no_overflow : assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !stat.full)
    else $error("command queue written while full");

  a_no_underflow : assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !stat.empty)
    else $error("command queue read while empty");

endmodule

// ===== design/bsfb_back.sv =====
// ----------------------------------------------------------------------------
// Byte-stuffed frame builder: back end
// Walks each command through its line bytes into the output register, one
// byte per cycle while the register is empty or being popped.
// ----------------------------------------------------------------------------
module bsfb_back
  import bsfb_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  bsfb_cmd_t    head_cmd,
  input  bsfb_q_stat_t q_stat,
  output logic         cmd_pop,
  input  logic         out_pop,
  output logic         out_empty,
  output bsfb_out_t    out_word
);

  typedef enum logic [3:0] {
    PH_START,
    PH_OPEN,
    PH_DATA,
    PH_DATA_ESC,
    PH_CRCH,
    PH_CRCH_ESC,
    PH_CRCL,
    PH_CRCL_ESC,
    PH_CLOSE
  } phase_t;

  phase_t    phase_r, phase_nxt, phase_cur;
  logic      out_valid_r;
  bsfb_out_t out_word_r;
  bsfb_out_t byte_nxt;
  logic      step_en;
  logic      cmd_done;
  logic      last_of_data;

  assign step_en   = !q_stat.empty && (!out_valid_r || out_pop);
  assign cmd_pop   = step_en && cmd_done;
  assign out_empty = !out_valid_r;
  assign out_word  = out_word_r;

  always_comb begin
    if (phase_r == PH_START) begin
      phase_cur = head_cmd.need_open ? PH_OPEN : PH_DATA;
    end else begin
      phase_cur = phase_r;
    end
    last_of_data        = !head_cmd.last;
    byte_nxt.line_byte  = FLAG_BYTE;
    byte_nxt.run_last   = 1'b0;
    byte_nxt.frame_done = 1'b0;
    phase_nxt           = phase_cur;
    cmd_done            = 1'b0;
    case (phase_cur)
      PH_OPEN: begin
        phase_nxt = PH_DATA;
      end
      PH_DATA: begin
        if (is_special(head_cmd.data_byte)) begin
          byte_nxt.line_byte = ESC_BYTE;
          phase_nxt          = PH_DATA_ESC;
        end else begin
          byte_nxt.line_byte = head_cmd.data_byte;
          byte_nxt.run_last  = last_of_data;
          cmd_done           = last_of_data;
          phase_nxt          = PH_CRCH;
        end
      end
      PH_DATA_ESC: begin
        byte_nxt.line_byte = head_cmd.data_byte ^ ESC_XOR;
        byte_nxt.run_last  = last_of_data;
        cmd_done           = last_of_data;
        phase_nxt          = PH_CRCH;
      end
      PH_CRCH: begin
        if (is_special(head_cmd.crc[15:8])) begin
          byte_nxt.line_byte = ESC_BYTE;
          phase_nxt          = PH_CRCH_ESC;
        end else begin
          byte_nxt.line_byte = head_cmd.crc[15:8];
          phase_nxt          = PH_CRCL;
        end
      end
      PH_CRCH_ESC: begin
        byte_nxt.line_byte = head_cmd.crc[15:8] ^ ESC_XOR;
        phase_nxt          = PH_CRCL;
      end
      PH_CRCL: begin
        if (is_special(head_cmd.crc[7:0])) begin
          byte_nxt.line_byte = ESC_BYTE;
          phase_nxt          = PH_CRCL_ESC;
        end else begin
          byte_nxt.line_byte = head_cmd.crc[7:0];
          phase_nxt          = PH_CLOSE;
        end
      end
      PH_CRCL_ESC: begin
        byte_nxt.line_byte = head_cmd.crc[7:0] ^ ESC_XOR;
        phase_nxt          = PH_CLOSE;
      end
      PH_CLOSE: begin
        byte_nxt.run_last   = 1'b1;
        byte_nxt.frame_done = 1'b1;
        cmd_done            = 1'b1;
      end
      default: begin
        phase_nxt = PH_START;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_START;
      out_valid_r <= 1'b0;
    end else if (step_en) begin
      out_word_r  <= byte_nxt;
      out_valid_r <= 1'b1;
      phase_r     <= cmd_done ? PH_START : phase_nxt;
    end else if (out_pop) begin
      out_valid_r <= 1'b0;
    end
  end

  // Mid-command phases only exist while their command is still queued.
  a_phase_has_cmd : assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != PH_START) |-> !q_stat.empty)
    else $error("back end mid-command with an empty queue");

  a_close_ends_run : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_word_r.frame_done |-> out_word_r.run_last
      && (out_word_r.line_byte == FLAG_BYTE))
    else $error("closing flag not marked as end of run");

endmodule

// ===== design/byte_stuffed_frame_builder_unit.sv =====
// ----------------------------------------------------------------------------
// Byte-stuffed frame builder
// HDLC-style asynchronous framer with byte stuffing and CRC-16 trailer.
// ----------------------------------------------------------------------------
// Payload words go in on the in_ queue side, one raw byte each with a
// last-byte marker; framed line bytes come out on the out_ queue side, one
// per cycle at most. The first word of a frame is preceded by an opening
// flag 0x7E. Every data byte equal to 0x7E or 0x7D is sent as 0x7D followed
// by the byte XOR 0x20. After the last byte the CRC-16 (polynomial 0x1021,
// preset 0xFFFF, MSB first, no reflection, no final XOR) over the raw
// payload follows, high byte then low byte, each escaped in the same way,
// and then a closing flag, which carries frame_done. run_last marks the
// final line byte produced by each input word. Timing: the front end takes
// one input word per cycle while its four-word command queue has room; the
// back end produces one line byte per cycle into the output register while
// a command is queued and the register is empty or being popped. Each input
// word yields one line byte for a plain mid-frame byte, two when escaped or
// frame-opening, and up to eight for an escaped single-byte frame. With an
// output that is popped every cycle the sustained rate is therefore set by
// the back end's one-byte-per-cycle sequencer. A word is first written into
// the command queue and its first line byte is then loaded into the output
// register, and only then can out_empty fall.
module byte_stuffed_frame_builder_unit
  import bsfb_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  output logic      in_full,
  input  bsfb_in_t  in_data,
  output logic      out_empty,
  input  logic      out_pop,
  output bsfb_out_t out_data
);

  bsfb_q_stat_t q_stat;
  bsfb_cmd_t    push_cmd;
  bsfb_cmd_t    head_cmd;
  logic         cmd_push;
  logic         cmd_pop;

  // The queue's fill state is the only backpressure the input side sees.
  assign in_full = q_stat.full;

  bsfb_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_word  (in_data),
    .q_stat   (q_stat),
    .cmd_push (cmd_push),
    .cmd      (push_cmd)
  );

  bsfb_cmd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (cmd_push),
    .push_cmd (push_cmd),
    .pop      (cmd_pop),
    .head_cmd (head_cmd),
    .stat     (q_stat)
  );

  bsfb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_cmd  (head_cmd),
    .q_stat    (q_stat),
    .cmd_pop   (cmd_pop),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_word  (out_data)
  );

endmodule
